>>> sv/cdrsf_pkg.sv
// Shared types and constants for the raw Mode 1 CD sector formatter.
// No dependencies; used by every cdrsf_* module and the top level.
`timescale 1ns / 1ps

package cdrsf_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_AREA_MASK     = 2'd0;
    localparam logic [1:0] CFG_START_BLOCK   = 2'd1;
    localparam logic [1:0] CFG_FORMAT_ENABLE = 2'd2;

    localparam int CFG_DATA_W = 19;

    // Action codes carried in tuser of the input stream
    localparam logic ACT_RESTART = 1'b0;
    localparam logic ACT_READ    = 1'b1;

    // Area mask bit positions
    localparam int MASK_SYNC   = 7;
    localparam int MASK_HEADER = 5;
    localparam int MASK_USER   = 4;
    localparam int MASK_AUX    = 3;
    localparam int MASK_EFLAG  = 1;
    localparam int MASK_SUBCH  = 0;

    // Area lengths in bytes
    localparam logic [11:0] LEN_SYNC   = 12'd12;
    localparam logic [11:0] LEN_HEADER = 12'd4;
    localparam logic [11:0] LEN_USER   = 12'd2048;
    localparam logic [11:0] LEN_AUX    = 12'd288;
    localparam logic [11:0] LEN_EFLAG  = 12'd294;
    localparam logic [11:0] LEN_SUBCH  = 12'd96;
    localparam logic [11:0] LEN_SECTOR = 12'd2742;

    localparam logic [19:0] LEAD_IN_BLOCKS = 20'd150;

    // Reciprocal constants: x/75 for x < 2^20, q/60 for q < 2^13
    localparam logic [19:0] RECIP_75       = 20'd894785;
    localparam int          RECIP_75_SHIFT = 26;
    localparam logic [13:0] RECIP_60       = 14'd8739;
    localparam int          RECIP_60_SHIFT = 19;

    localparam logic [6:0] FRAMES_PER_SEC = 7'd75;
    localparam logic [5:0] SECS_PER_MIN   = 6'd60;

    localparam logic [15:0] WORD_SYNC_HEAD = 16'h00FF;
    localparam logic [15:0] WORD_SYNC_TAIL = 16'hFF00;
    localparam logic [15:0] WORD_ONES      = 16'hFFFF;
    localparam logic [7:0]  HEADER_MODE    = 8'h01;

    typedef struct packed {
        logic [7:0]  area_mask;
        logic        format_enable;
        logic [19:0] start_x;     // start_block + lead-in
        logic [12:0] start_q75;   // start_x / 75
    } t_cfg;

    typedef struct packed {
        logic [7:0] minute;
        logic [5:0] second;
        logic [6:0] frame;
    } t_msf;

    typedef struct packed {
        logic [15:0] data_word;
        logic        user_taken;
        logic        block_end;
    } t_result;

endpackage

>>> sv/cdrsf_cfg.sv
// Configuration register file: area mask, start block, format enable.
// Start block is stored pre-split as (block+150) and its quotient by 75.
`timescale 1ns / 1ps

module cdrsf_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [cdrsf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output cdrsf_pkg::t_cfg                o_cfg
);

    cdrsf_pkg::t_cfg r_cfg;
    logic [19:0]     wr_x;
    logic [39:0]     wr_prod;

    assign wr_x    = {1'b0, i_cfg_wdata} + cdrsf_pkg::LEAD_IN_BLOCKS;
    assign wr_prod = wr_x * cdrsf_pkg::RECIP_75;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.area_mask     <= '0;
            r_cfg.format_enable <= 1'b0;
            r_cfg.start_x       <= cdrsf_pkg::LEAD_IN_BLOCKS;
            r_cfg.start_q75     <= 13'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cdrsf_pkg::CFG_AREA_MASK: begin
                    r_cfg.area_mask <= i_cfg_wdata[7:0];
                end
                cdrsf_pkg::CFG_START_BLOCK: begin
                    r_cfg.start_x   <= wr_x;
                    r_cfg.start_q75 <= wr_prod[cdrsf_pkg::RECIP_75_SHIFT +: 13];
                end
                cdrsf_pkg::CFG_FORMAT_ENABLE: begin
                    r_cfg.format_enable <= i_cfg_wdata[0];
                end
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg.start_q75 <= 13'd6992)
        else $error("start quotient out of range");

endmodule

>>> sv/cdrsf_msf.sv
// Block address counter held as minute/second/frame.
// Loads from the pre-split start address on restart; steps on sector wrap.
`timescale 1ns / 1ps

module cdrsf_msf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cdrsf_pkg::t_cfg i_cfg,
    input  logic            i_restart,
    input  logic            i_advance,
    output cdrsf_pkg::t_msf o_msf
);

    cdrsf_pkg::t_msf r_msf;
    cdrsf_pkg::t_msf n_msf;
    cdrsf_pkg::t_msf ld_msf;
    logic [19:0]     q75_x75;
    logic [19:0]     frame_full;
    logic [26:0]     min_prod;
    logic [7:0]      ld_minute;
    logic [12:0]     min_x60;
    logic [12:0]     sec_full;

    // frame = x - 75*q ; 75 = 64 + 8 + 2 + 1
    assign q75_x75    = ({7'd0, i_cfg.start_q75} << 6) + ({7'd0, i_cfg.start_q75} << 3)
                      + ({7'd0, i_cfg.start_q75} << 1) + {7'd0, i_cfg.start_q75};
    assign frame_full = i_cfg.start_x - q75_x75;

    assign min_prod  = i_cfg.start_q75 * cdrsf_pkg::RECIP_60;
    assign ld_minute = min_prod[cdrsf_pkg::RECIP_60_SHIFT +: 8];
    // second = q - 60*minute ; 60 = 64 - 4
    assign min_x60   = ({5'd0, ld_minute} << 6) - ({5'd0, ld_minute} << 2);
    assign sec_full  = i_cfg.start_q75 - min_x60;

    always_comb begin
        ld_msf.minute = ld_minute;
        ld_msf.second = sec_full[5:0];
        ld_msf.frame  = frame_full[6:0];

        n_msf = r_msf;
        if (i_restart) begin
            n_msf = ld_msf;
        end else if (i_advance) begin
            if (r_msf.frame + 7'd1 >= cdrsf_pkg::FRAMES_PER_SEC) begin
                n_msf.frame = '0;
                if (r_msf.second + 6'd1 >= cdrsf_pkg::SECS_PER_MIN) begin
                    n_msf.second = '0;
                    n_msf.minute = r_msf.minute + 8'd1;
                end else begin
                    n_msf.second = r_msf.second + 6'd1;
                end
            end else begin
                n_msf.frame = r_msf.frame + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msf.minute <= 8'd0;
            r_msf.second <= 6'd2;
            r_msf.frame  <= 7'd0;
        end else begin
            r_msf <= n_msf;
        end
    end

    assign o_msf = r_msf;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_msf.frame < cdrsf_pkg::FRAMES_PER_SEC && r_msf.second < cdrsf_pkg::SECS_PER_MIN)
        else $error("msf field out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_restart |=> r_msf.frame == $past(ld_msf.frame))
        else $error("restart did not load frame");

endmodule

>>> sv/cdrsf_layout.sv
// Sector layout decode: byte offset register, area selection and word build.
// Depends on cdrsf_pkg; drives the block advance strobe of cdrsf_msf.
`timescale 1ns / 1ps

module cdrsf_layout (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cdrsf_pkg::t_cfg   i_cfg,
    input  cdrsf_pkg::t_msf   i_msf,
    input  logic              i_step,
    input  logic              i_action,
    input  logic [15:0]       i_user_word,
    output cdrsf_pkg::t_result o_result,
    output logic              o_advance
);

    logic [11:0] r_offset;
    logic [11:0] n_offset;
    logic [11:0] stop_sync, stop_hdr, stop_usr, stop_aux, stop_ef, stop_sub;
    logic [12:0] off_inc;
    logic        wrap;
    logic        fmt_read;
    logic        in_sync, in_hdr, in_usr, in_zero;
    logic [11:0] hdr_rel;
    logic [7:0]  m;

    assign m = i_cfg.area_mask;

    assign stop_sync = m[cdrsf_pkg::MASK_SYNC]   ? cdrsf_pkg::LEN_SYNC : 12'd0;
    assign stop_hdr  = stop_sync + (m[cdrsf_pkg::MASK_HEADER] ? cdrsf_pkg::LEN_HEADER : 12'd0);
    assign stop_usr  = stop_hdr  + (m[cdrsf_pkg::MASK_USER]   ? cdrsf_pkg::LEN_USER   : 12'd0);
    assign stop_aux  = stop_usr  + (m[cdrsf_pkg::MASK_AUX]    ? cdrsf_pkg::LEN_AUX    : 12'd0);
    assign stop_ef   = stop_aux  + (m[cdrsf_pkg::MASK_EFLAG]  ? cdrsf_pkg::LEN_EFLAG  : 12'd0);
    assign stop_sub  = stop_ef   + (m[cdrsf_pkg::MASK_SUBCH]  ? cdrsf_pkg::LEN_SUBCH  : 12'd0);

    // Disabled areas have start == stop, so the range test alone gates them.
    assign in_sync = r_offset < stop_sync;
    assign in_hdr  = r_offset >= stop_sync && r_offset < stop_hdr;
    assign in_usr  = r_offset >= stop_hdr  && r_offset < stop_usr;
    assign in_zero = r_offset >= stop_usr  && r_offset < stop_sub;
    assign hdr_rel = r_offset - stop_sync;

    assign fmt_read = (i_action == cdrsf_pkg::ACT_READ) && i_cfg.format_enable;
    assign off_inc  = {1'b0, r_offset} + 13'd2;
    assign wrap     = off_inc >= {1'b0, stop_sub};

    always_comb begin
        o_result = '0;
        if (i_action == cdrsf_pkg::ACT_READ) begin
            if (!i_cfg.format_enable) begin
                o_result.data_word  = i_user_word;
                o_result.user_taken = 1'b1;
            end else begin
                o_result.data_word = cdrsf_pkg::WORD_ONES;
                if (in_sync) begin
                    if (r_offset == 12'd0) begin
                        o_result.data_word = cdrsf_pkg::WORD_SYNC_HEAD;
                    end else if (r_offset == 12'd10) begin
                        o_result.data_word = cdrsf_pkg::WORD_SYNC_TAIL;
                    end
                end else if (in_hdr) begin
                    o_result.data_word = (hdr_rel == 12'd0)
                        ? {i_msf.minute, 2'b00, i_msf.second}
                        : {1'b0, i_msf.frame, cdrsf_pkg::HEADER_MODE};
                end else if (in_usr) begin
                    o_result.data_word  = i_user_word;
                    o_result.user_taken = 1'b1;
                end else if (in_zero) begin
                    o_result.data_word = '0;
                end
                o_result.block_end = (stop_sub != 12'd0) && wrap;
            end
        end
    end

    assign o_advance = i_step && fmt_read && (stop_sub != 12'd0) && wrap;

    always_comb begin
        n_offset = r_offset;
        if (i_step) begin
            if (i_action == cdrsf_pkg::ACT_RESTART) begin
                n_offset = '0;
            end else if (fmt_read && stop_sub != 12'd0) begin
                n_offset = wrap ? 12'd0 : off_inc[11:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else begin
            r_offset <= n_offset;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset < cdrsf_pkg::LEN_SECTOR && !r_offset[0])
        else $error("byte offset out of range or odd");

endmodule

>>> sv/cd_mode1_raw_sector_formatter_unit.sv
// Top level of the raw Mode 1 CD sector formatter.
// Uses cdrsf_pkg, cdrsf_cfg, cdrsf_msf and cdrsf_layout.
//
// Usage:
//  - Input stream (s_axis): one beat per host word request. tuser carries the
//    action (0 restart at the start block, 1 read one word), tdata the next
//    user word from the sector source.
//  - Output stream (m_axis): exactly one beat per input beat. tdata is the
//    host word (first byte in the high half), tuser says the user word was
//    consumed, tlast marks the word that completes a sector.
//  - Configuration: write enable, index (0 area mask, 1 start block,
//    2 format enable) and data; to be written while the block is idle.
//  - An accepted beat is held in the input register, its result in the output
//    register until taken. Throughput is one beat per cycle without stalls;
//    the only loop is the byte offset and block address registers.
//  - A restart loads the address from a quotient computed at the start
//    block write, so a restart may directly follow that write.
//  - Reset (synchronous, active low) clears the config, sets offset 0 and
//    address 00:02:00, and empties the pipeline.
//  - When the receiver stalls, the result is held and one more input beat is
//    taken into the input register; tready then drops until the stall ends.
`timescale 1ns / 1ps

module cd_mode1_raw_sector_formatter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] user_word
    input  logic        i_s_axis_tuser,   // [0] action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] data_word
    output logic        o_m_axis_tuser,   // [0] user_taken
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [cdrsf_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    cdrsf_pkg::t_cfg    cfg;
    cdrsf_pkg::t_msf    msf;
    cdrsf_pkg::t_result res;
    logic               advance;

    logic               r_s1_valid;
    logic               r_s1_action;
    logic [15:0]        r_s1_user;
    logic               r_out_valid;
    cdrsf_pkg::t_result r_out;

    logic s1_adv;
    logic in_beat;
    logic step;

    assign s1_adv          = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign step            = r_s1_valid && s1_adv;

    cdrsf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    cdrsf_msf u_msf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_restart (step && r_s1_action == cdrsf_pkg::ACT_RESTART),
        .i_advance (advance),
        .o_msf     (msf)
    );

    cdrsf_layout u_layout (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_msf       (msf),
        .i_step      (step),
        .i_action    (r_s1_action),
        .i_user_word (r_s1_user),
        .o_result    (res),
        .o_advance   (advance)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
        if (in_beat) begin
            r_s1_action <= i_s_axis_tuser;
            r_s1_user   <= i_s_axis_tdata;
        end
        if (step) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.data_word;
    assign o_m_axis_tuser  = r_out.user_taken;
    assign o_m_axis_tlast  = r_out.block_end;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid)
        else $error("held input beat was dropped");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_s1_valid && r_out_valid)
        else $error("tready low with free stage");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed beat produced no result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |-> step && res.block_end)
        else $error("block advance without sector end");

endmodule

>>> tb/sv/cdrsf_word_checker.sv
// Checker for the raw Mode 1 CD sector formatter: watches the config port and both streams,
// predicts each output beat from the input beats and compares field by field.
// Depends on cdrsf_pkg.
`timescale 1ns / 1ps

module cdrsf_word_checker
    import cdrsf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    input  logic                    i_s_tready,
    input  logic [15:0]             i_s_tdata,   // [15:0] user_word
    input  logic                    i_s_tuser,   // [0] action
    input  logic                    i_m_tvalid,
    input  logic                    i_m_tready,
    input  logic [15:0]             i_m_tdata,   // [15:0] data_word
    input  logic                    i_m_tuser,   // [0] user_taken
    input  logic                    i_m_tlast,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int unsigned FRAMES_PER_MIN = 4500;
    localparam int unsigned SYNC_TAIL_AT   = 10;
    localparam int          PRINT_CAP      = 50;
    localparam t_msf        ADDR_AT_RESET  = '{minute: 8'd0, second: 6'd2, frame: 7'd0};

    logic [7:0]            mask_reg  = '0;
    logic [CFG_DATA_W-1:0] start_reg = '0;
    logic                  fmt_reg   = 1'b0;
    logic [11:0]           offset    = '0;
    t_msf                  addr      = ADDR_AT_RESET;

    t_result expected_words[$];
    int      fails       = 0;
    int      pending_cnt = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending_cnt;

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        if (fails < PRINT_CAP)
            $display("%0t ns: %s mismatch, expected %h got %h", $time, what, want, got);
        fails++;
    endtask

    function automatic t_result format_next_word(input logic act, input logic [15:0] word);
        t_result     r;
        int unsigned x, lo, hi, off;
        r   = '0;
        lo  = 0;
        hi  = 0;
        off = offset;
        if (act == ACT_RESTART) begin
            x           = start_reg + LEAD_IN_BLOCKS;
            offset      = '0;
            addr.minute = 8'(x / FRAMES_PER_MIN);
            addr.second = 6'((x / FRAMES_PER_SEC) % SECS_PER_MIN);
            addr.frame  = 7'(x % FRAMES_PER_SEC);
        end else if (!fmt_reg) begin
            r.data_word  = word;
            r.user_taken = 1'b1;
        end else begin
            r.data_word = WORD_ONES;
            if (mask_reg[MASK_SYNC]) begin
                lo = hi;
                hi += LEN_SYNC;
                if (off >= lo && off < hi)
                    r.data_word = (off == lo) ? WORD_SYNC_HEAD :
                                  (off == lo + SYNC_TAIL_AT) ? WORD_SYNC_TAIL : WORD_ONES;
            end
            if (mask_reg[MASK_HEADER]) begin
                lo = hi;
                hi += LEN_HEADER;
                if (off >= lo && off < hi)
                    r.data_word = (off == lo) ? {addr.minute, 2'b00, addr.second}
                                              : {1'b0, addr.frame, HEADER_MODE};
            end
            if (mask_reg[MASK_USER]) begin
                lo = hi;
                hi += LEN_USER;
                if (off >= lo && off < hi) begin
                    r.data_word  = word;
                    r.user_taken = 1'b1;
                end
            end
            // aux, error flags and subchannel are zero-filled
            if (mask_reg[MASK_AUX]) begin
                lo = hi;
                hi += LEN_AUX;
                if (off >= lo && off < hi) r.data_word = '0;
            end
            if (mask_reg[MASK_EFLAG]) begin
                lo = hi;
                hi += LEN_EFLAG;
                if (off >= lo && off < hi) r.data_word = '0;
            end
            if (mask_reg[MASK_SUBCH]) begin
                lo = hi;
                hi += LEN_SUBCH;
                if (off >= lo && off < hi) r.data_word = '0;
            end
            // empty mask: no sector, offset and address hold
            if (hi != 0) begin
                off += 2;
                if (off >= hi) begin
                    off         = 0;
                    r.block_end = 1'b1;
                    if (addr.frame == FRAMES_PER_SEC - 1) begin
                        addr.frame = '0;
                        if (addr.second == SECS_PER_MIN - 1) begin
                            addr.second = '0;
                            addr.minute = addr.minute + 8'd1;
                        end else begin
                            addr.second = addr.second + 6'd1;
                        end
                    end else begin
                        addr.frame = addr.frame + 7'd1;
                    end
                end
                offset = 12'(off);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            mask_reg  = '0;
            start_reg = '0;
            fmt_reg   = 1'b0;
            offset    = '0;
            addr      = ADDR_AT_RESET;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_AREA_MASK:     mask_reg  = i_cfg_wdata[7:0];
                    CFG_START_BLOCK:   start_reg = i_cfg_wdata;
                    CFG_FORMAT_ENABLE: fmt_reg   = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                expected_words.push_back(format_next_word(i_s_tuser, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = '{data_word: i_m_tdata, user_taken: i_m_tuser, block_end: i_m_tlast};
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected beat, data_word", '0, got.data_word);
                end else begin
                    want = expected_words.pop_front();
                    if (got.data_word !== want.data_word)
                        report_mismatch("data_word", want.data_word, got.data_word);
                    if (got.user_taken !== want.user_taken)
                        report_mismatch("user_taken", want.user_taken, got.user_taken);
                    if (got.block_end !== want.block_end)
                        report_mismatch("block_end", want.block_end, got.block_end);
                end
            end
        end
        pending_cnt = expected_words.size();
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the sector formatter testbench: clock, reset, config writes, input beats and
// receiver backpressure; verdict from cdrsf_word_checker. Depends on cdrsf_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import cdrsf_pkg::*;

    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          HOLD_CYCLES     = 200;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int unsigned START_BLOCK_MAX = 449849;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic                  s_tuser   = ACT_READ;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_index = CFG_AREA_MASK;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int   send_idle_pct = 15;
    int   recv_idle_pct = 76;
    logic hold_go       = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_left     = 0;
    int   cycles        = 0;
    int   fail_count;
    int   words_pending;

    cd_mode1_raw_sector_formatter_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    cdrsf_word_checker u_word_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (words_pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off so the block backs up
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_go && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_word(input logic act, input logic [15:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] mask, input int unsigned start_blk,
                              input logic fmt);
        write_reg(CFG_AREA_MASK, mask);
        write_reg(CFG_START_BLOCK, start_blk);
        write_reg(CFG_FORMAT_ENABLE, fmt);
    endtask

    task automatic random_phase(input int n_items, input logic long_stall);
        logic [7:0]  mask;
        int unsigned start_blk;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            // short sectors so block ends come often
            mask = 8'($urandom) & 8'hE4;
            if ($urandom_range(99) < 30) mask[MASK_SUBCH] = 1'b1;
        end else if (pick < 75) begin
            mask = (8'($urandom) & 8'hE5) | (8'h1 << MASK_USER);
        end else begin
            mask = 8'($urandom);
        end
        pick = $urandom_range(99);
        start_blk = (pick < 10) ? 0 : (pick < 20) ? START_BLOCK_MAX
                                                  : $urandom_range(START_BLOCK_MAX);
        set_config(mask, start_blk, $urandom_range(99) < 85);
        hold_go <= long_stall;
        if ($urandom_range(99) < 75) push_word(ACT_RESTART, 16'($urandom));
        repeat (n_items) begin
            if ($urandom_range(99) < 6) push_word(ACT_RESTART, 16'($urandom));
            else                        push_word(ACT_READ, 16'($urandom));
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // pass-through after reset, restart with formatting off
        settle();
        push_word(ACT_READ, 16'h0000);
        push_word(ACT_READ, 16'hFFFF);
        push_word(ACT_READ, 16'h5AA5);
        push_word(ACT_RESTART, 16'hFFFF);
        // formatting on with nothing selected
        write_reg(CFG_FORMAT_ENABLE, 1);
        push_word(ACT_READ, 16'h1234);
        // sync + header at the last block: frame and second roll into minute
        write_reg(CFG_AREA_MASK, (1 << MASK_SYNC) | (1 << MASK_HEADER));
        write_reg(CFG_START_BLOCK, START_BLOCK_MAX);
        push_word(ACT_RESTART, 16'hBEEF);
        repeat (12) push_word(ACT_READ, 16'($urandom));
        // shrink the sector under the current offset
        write_reg(CFG_AREA_MASK, 1 << MASK_HEADER);
        push_word(ACT_READ, 16'h0F0F);
        push_word(ACT_READ, 16'hF0F0);
        // every mask bit, start block zero
        set_config(8'hFF, 0, 1'b1);
        push_word(ACT_RESTART, 16'h8001);
        push_word(ACT_READ, 16'h7FFE);
        push_word(ACT_READ, 16'h0001);
        // only the unused mask bits: no sector
        write_reg(CFG_AREA_MASK, 8'h44);
        push_word(ACT_READ, 16'hAAAA);

        for (int p = 0; p < 15; p++) begin
            if (p == 5) begin
                send_idle_pct = 76;
                recv_idle_pct = 15;
            end
            if (p == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_phase($urandom_range(20, 46), p == 11);
        end

        settle();
        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
